### rtl/core/aarm_pkg.sv
// Shared constants and types of the ALOHA acknowledged MAC.
`timescale 1ns / 1ps
`default_nettype none
package aarm_pkg;

  localparam int PENDING_DEPTH_DEF = 16;
  localparam int HISTORY_DEPTH_DEF = 128;

  localparam int ADDR_W   = 8;
  localparam int SERIAL_W = 16;
  localparam int DELAY_W  = 16;
  localparam int BUDGET_W = 3;
  localparam int CNT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ADDR_W-1:0] BCAST_ADDR = 8'hFF;

  // Operation codes of an input item.
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_RECV    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Frame kinds.
  localparam logic FT_DATA = 1'b0;
  localparam logic FT_ACK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRY = 2'd3;

  localparam logic [ADDR_W-1:0]   OWN_ADDR_RST  = 8'd1;
  localparam logic [DELAY_W-1:0]  MIN_DELAY_RST = 16'd1;
  localparam logic [DELAY_W-1:0]  RANGE_RST     = 16'd4;
  localparam logic [BUDGET_W-1:0] MAX_RETRY_RST = 3'd3;

  typedef enum logic [2:0] {
    ACT_TX_DATA = 3'd0,
    ACT_TX_ACK  = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_RETX    = 3'd3,
    ACT_ARM     = 3'd4,
    ACT_DONE    = 3'd5,
    ACT_DISCARD = 3'd6
  } act_t;

endpackage
`default_nettype wire

### rtl/core/aarm_if.sv
// Channel interfaces of the ALOHA acknowledged MAC.
`timescale 1ns / 1ps
`default_nettype none
interface aarm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  dest_addr;
  logic [7:0]  src_addr;
  logic        frame_type;
  logic [15:0] serial;
  logic [15:0] random_draw;
  modport source (output valid, operation, dest_addr, src_addr, frame_type, serial,
                  random_draw, input ready);
  modport sink (input valid, operation, dest_addr, src_addr, frame_type, serial,
                random_draw, output ready);
endinterface

interface aarm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        out_type;
  logic [7:0]  out_dest;
  logic [7:0]  out_source;
  logic [15:0] out_serial;
  logic [16:0] timer_delay;
  logic [31:0] discard_total;
  logic        last;
  modport source (output valid, action, out_type, out_dest, out_source, out_serial,
                  timer_delay, discard_total, last, input ready);
  modport sink (input valid, action, out_type, out_dest, out_source, out_serial,
                timer_delay, discard_total, last, output ready);
endinterface

interface aarm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/core/aarm_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module aarm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/core/aarm_rem.sv
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aarm_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [aarm_pkg::DELAY_W-1:0]  num,
  input  logic [aarm_pkg::DELAY_W-1:0]  den,
  output logic                          busy,
  output logic [aarm_pkg::DELAY_W-1:0]  rem
);
  import aarm_pkg::*;

  localparam int SW = $clog2(DELAY_W + 1);

  logic            busy_r;
  logic [SW-1:0]   cnt_r;
  logic [DELAY_W-1:0] num_r;
  logic [DELAY_W-1:0] den_r;
  logic [DELAY_W-1:0] rem_r;
  logic [DELAY_W:0]   trial;
  logic [DELAY_W:0]   diff;

  assign trial = {rem_r, num_r[DELAY_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DELAY_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_r <= diff[DELAY_W-1:0];
      end else begin
        rem_r <= trial[DELAY_W-1:0];
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == SW'(DELAY_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // A zero span adds no random delay.
  assign rem  = (den_r == '0) ? '0 : rem_r;
  assign busy = busy_r;

endmodule
`default_nettype wire

### rtl/core/aloha_ack_retransmit_mac.sv
// Top level of the ALOHA MAC with acknowledgement and retransmission.
//
//  port     | direction | carries
//  ---------+-----------+-------------------------------------------------
//  in_ch    | sink      | send request, received header or timeout item
//  out_ch   | source    | one action item, last marks the end of an input
//  cfg_ch   | sink      | register index and write data, always ready
//
// With a free output, a unicast send passes in order through a pending table
// search that reads one RAM entry a cycle, the update state, the wait state for
// the remainder unit that starts at acceptance, and the emit state, which issues
// its results in order. Received data for this node searches the history RAM;
// an ACK and a timeout search the pending table, and an item with no search goes
// straight to the emit state or stays idle.
// Reset is synchronous; valid flags of the pending table and the history fill
// count clear at once, so no clearing pass is needed. A stalled output holds
// the block in its emit state; the input is taken only when the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module aloha_ack_retransmit_mac #(
  parameter int PENDING_DEPTH = aarm_pkg::PENDING_DEPTH_DEF,
  parameter int HISTORY_DEPTH = aarm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  aarm_in_if.sink      in_ch,
  aarm_out_if.source   out_ch,
  aarm_cfg_if.sink     cfg_ch
);
  import aarm_pkg::*;

  localparam int PIW    = $clog2(PENDING_DEPTH);
  localparam int HIW    = $clog2(HISTORY_DEPTH);
  localparam int MAXD   = (PENDING_DEPTH > HISTORY_DEPTH) ? PENDING_DEPTH : HISTORY_DEPTH;
  localparam int CW     = $clog2(MAXD + 1);
  localparam int PEND_W = SERIAL_W + ADDR_W + BUDGET_W;
  localparam int HIST_W = SERIAL_W + ADDR_W;
  localparam logic [CW-1:0]  PD_C     = CW'(PENDING_DEPTH);
  localparam logic [CW-1:0]  HD_C     = CW'(HISTORY_DEPTH);
  localparam logic [HIW-1:0] HEAD_MAX = HIW'(HISTORY_DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_UPD  = 5'b00100,
    S_WAIT = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;

  // Configuration.
  logic [ADDR_W-1:0]   own_r;
  logic [DELAY_W-1:0]  min_r;
  logic [DELAY_W-1:0]  range_r;
  logic [BUDGET_W-1:0] maxr_r;

  // Current item.
  logic [1:0]          op_r;
  logic [ADDR_W-1:0]   dst_r;
  logic [ADDR_W-1:0]   src_r;
  logic                ftype_r;
  logic [SERIAL_W-1:0] ser_r;
  logic [ADDR_W-1:0]   tdest_r;

  // Persistent state held in flops.
  logic [SERIAL_W-1:0]      next_serial_r;
  logic [CNT_W-1:0]         disc_r;
  logic [HIW-1:0]           head_r;
  logic [CW-1:0]            hfill_r;
  logic [PENDING_DEPTH-1:0] pvalid_r;

  // Search state.
  logic                hist_r;
  logic [CW-1:0]       issue_r;
  logic                rvld_r;
  logic [CW-1:0]       ridx_r;
  logic                hit_r;
  logic [PIW-1:0]      hidx_r;
  logic [ADDR_W-1:0]   hdest_r;
  logic [BUDGET_W-1:0] hbud_r;
  logic                free_r;
  logic [PIW-1:0]      fidx_r;
  logic                dup_r;

  // Result list.
  act_t      acts_r [3];
  logic [1:0] nres_r;
  logic [1:0] eidx_r;

  // Output register.
  logic                ov_r;
  logic                ov_nxt;
  logic [2:0]          o_act_r;
  logic                o_type_r;
  logic [ADDR_W-1:0]   o_dest_r;
  logic [ADDR_W-1:0]   o_src_r;
  logic [SERIAL_W-1:0] o_ser_r;
  logic [DELAY_W:0]    o_delay_r;
  logic [CNT_W-1:0]    o_disc_r;
  logic                o_last_r;

  // Memories and remainder unit.
  logic              pend_we;
  logic [PIW-1:0]    pend_waddr;
  logic [PEND_W-1:0] pend_wdata;
  logic [PEND_W-1:0] pend_rdata;
  logic              hist_we;
  logic [HIST_W-1:0] hist_rdata;
  logic              div_busy;
  logic [DELAY_W-1:0] div_rem;

  logic                in_fire;
  logic                out_free;
  logic [CW-1:0]       scan_lim;
  logic [PIW-1:0]      pidx;
  logic [SERIAL_W-1:0] p_ser;
  logic [ADDR_W-1:0]   p_dst;
  logic [BUDGET_W-1:0] p_bud;
  logic [SERIAL_W-1:0] h_ser;
  logic [ADDR_W-1:0]   h_src;
  logic                h_valid;
  act_t                cur_act;
  logic [PIW-1:0]      slot;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_free = !ov_r || out_ch.ready;

  assign scan_lim = hist_r ? HD_C : PD_C;
  assign pidx     = ridx_r[PIW-1:0];
  assign p_ser    = pend_rdata[PEND_W-1 -: SERIAL_W];
  assign p_dst    = pend_rdata[BUDGET_W +: ADDR_W];
  assign p_bud    = pend_rdata[BUDGET_W-1:0];
  assign h_ser    = hist_rdata[HIST_W-1 -: SERIAL_W];
  assign h_src    = hist_rdata[ADDR_W-1:0];
  assign h_valid  = (ridx_r < hfill_r);
  assign cur_act  = acts_r[eidx_r];
  assign slot     = hit_r ? hidx_r : fidx_r;

  // The output register loads in the emit state and empties when taken.
  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    if (state_r == S_EMIT && out_free) begin
      ov_nxt = 1'b1;
    end
  end

  // Table writes happen only in the update state after a search.
  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = slot;
    pend_wdata = {ser_r, dst_r, maxr_r};
    hist_we    = 1'b0;
    if (state_r == S_UPD) begin
      if (op_r == OP_SEND) begin
        pend_we = hit_r || free_r;
      end else if (op_r == OP_TIMEOUT && hit_r && hbud_r > BUDGET_W'(1)) begin
        pend_we    = 1'b1;
        pend_waddr = hidx_r;
        pend_wdata = {ser_r, hdest_r, hbud_r - 1'b1};
      end
      hist_we = (op_r == OP_RECV) && (ftype_r == FT_DATA);
    end
  end

  aarm_ram #(.WIDTH(PEND_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (issue_r[PIW-1:0]),
    .rdata (pend_rdata)
  );

  aarm_ram #(.WIDTH(HIST_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_r),
    .wdata ({ser_r, src_r}),
    .raddr (issue_r[HIW-1:0]),
    .rdata (hist_rdata)
  );

  aarm_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .num   (in_ch.random_draw),
    .den   (range_r),
    .busy  (div_busy),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      own_r         <= OWN_ADDR_RST;
      min_r         <= MIN_DELAY_RST;
      range_r       <= RANGE_RST;
      maxr_r        <= MAX_RETRY_RST;
      next_serial_r <= '0;
      disc_r        <= '0;
      head_r        <= '0;
      hfill_r       <= '0;
      pvalid_r      <= '0;
      ov_r          <= 1'b0;
      rvld_r        <= 1'b0;
      issue_r       <= '0;
      nres_r        <= '0;
      eidx_r        <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_OWN_ADDR:  own_r   <= cfg_ch.data[ADDR_W-1:0];
          REG_MIN_DELAY: min_r   <= cfg_ch.data;
          REG_RANGE:     range_r <= cfg_ch.data;
          REG_MAX_RETRY: maxr_r  <= cfg_ch.data[BUDGET_W-1:0];
          default: ;
        endcase
      end

      ov_r <= ov_nxt;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_ch.operation;
            dst_r   <= in_ch.dest_addr;
            src_r   <= in_ch.src_addr;
            ftype_r <= in_ch.frame_type;
            tdest_r <= in_ch.dest_addr;
            ser_r   <= (in_ch.operation == OP_SEND) ? next_serial_r : in_ch.serial;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            dup_r   <= 1'b0;
            issue_r <= '0;
            rvld_r  <= 1'b0;
            hist_r  <= (in_ch.operation == OP_RECV) && (in_ch.frame_type == FT_DATA) &&
                       (in_ch.dest_addr == own_r);
            eidx_r  <= '0;
            priority if (in_ch.operation == OP_SEND) begin
              next_serial_r <= next_serial_r + 1'b1;
              if (in_ch.dest_addr != BCAST_ADDR) begin
                state_r <= S_SCAN;
              end else begin
                acts_r[0] <= ACT_TX_DATA;
                acts_r[1] <= ACT_DONE;
                nres_r    <= 2'd2;
                state_r   <= S_EMIT;
              end
            end else if (in_ch.operation == OP_RECV) begin
              if (in_ch.frame_type == FT_ACK) begin
                state_r <= S_SCAN;
              end else if (in_ch.dest_addr == own_r) begin
                state_r <= S_SCAN;
              end else if (in_ch.dest_addr == BCAST_ADDR) begin
                acts_r[0] <= ACT_DELIVER;
                nres_r    <= 2'd1;
                state_r   <= S_EMIT;
              end
            end else if (in_ch.operation == OP_TIMEOUT) begin
              state_r <= S_SCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end

        S_SCAN: begin
          // Reads are issued one entry a cycle; data returns in the next cycle.
          rvld_r <= (issue_r != scan_lim);
          ridx_r <= issue_r;
          if (issue_r != scan_lim) begin
            issue_r <= issue_r + 1'b1;
          end
          if (rvld_r) begin
            if (hist_r) begin
              if (h_valid && h_ser == ser_r && h_src == src_r) begin
                dup_r <= 1'b1;
              end
            end else begin
              if (pvalid_r[pidx] && p_ser == ser_r && !hit_r) begin
                hit_r   <= 1'b1;
                hidx_r  <= pidx;
                hdest_r <= p_dst;
                hbud_r  <= p_bud;
              end
              if (!pvalid_r[pidx] && !free_r) begin
                free_r <= 1'b1;
                fidx_r <= pidx;
              end
            end
          end else if (issue_r == scan_lim) begin
            state_r <= S_UPD;
          end
        end

        S_UPD: begin
          priority if (op_r == OP_SEND) begin
            if (hit_r || free_r) begin
              pvalid_r[slot] <= 1'b1;
            end
            acts_r[0] <= ACT_TX_DATA;
            acts_r[1] <= ACT_ARM;
            acts_r[2] <= ACT_DONE;
            nres_r    <= 2'd3;
            state_r   <= S_WAIT;
          end else if (op_r == OP_RECV) begin
            if (ftype_r == FT_DATA) begin
              head_r <= (head_r == HEAD_MAX) ? '0 : head_r + 1'b1;
              if (hfill_r != HD_C) begin
                hfill_r <= hfill_r + 1'b1;
              end
              if (dup_r) begin
                acts_r[0] <= ACT_TX_ACK;
                nres_r    <= 2'd1;
              end else begin
                acts_r[0] <= ACT_DELIVER;
                acts_r[1] <= ACT_TX_ACK;
                nres_r    <= 2'd2;
              end
              state_r <= S_EMIT;
            end else begin
              if (hit_r && hdest_r == src_r && dst_r == own_r) begin
                pvalid_r[hidx_r] <= 1'b0;
              end
              state_r <= S_IDLE;
            end
          end else if (op_r == OP_TIMEOUT && hit_r) begin
            tdest_r   <= hdest_r;
            acts_r[0] <= ACT_RETX;
            nres_r    <= 2'd2;
            if (hbud_r <= BUDGET_W'(1)) begin
              pvalid_r[hidx_r] <= 1'b0;
              acts_r[1] <= ACT_DISCARD;
              state_r   <= S_EMIT;
            end else begin
              acts_r[1] <= ACT_ARM;
              state_r   <= S_WAIT;
            end
          end else begin
            state_r <= S_IDLE;
          end
        end

        S_WAIT: begin
          if (!div_busy) begin
            state_r <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            o_act_r   <= cur_act;
            o_type_r  <= (cur_act == ACT_TX_ACK);
            o_dest_r  <= (cur_act == ACT_TX_ACK) ? src_r : tdest_r;
            o_src_r   <= (cur_act == ACT_DELIVER) ? src_r : own_r;
            o_ser_r   <= ser_r;
            o_delay_r <= (cur_act == ACT_ARM) ? ({1'b0, div_rem} + {1'b0, min_r}) : '0;
            o_last_r  <= (eidx_r == nres_r - 1'b1);
            if (cur_act == ACT_DISCARD) begin
              disc_r   <= disc_r + 1'b1;
              o_disc_r <= disc_r + 1'b1;
            end else begin
              o_disc_r <= disc_r;
            end
            eidx_r <= eidx_r + 1'b1;
            if (eidx_r == nres_r - 1'b1) begin
              state_r <= S_IDLE;
            end
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.action        = o_act_r;
  assign out_ch.out_type      = o_type_r;
  assign out_ch.out_dest      = o_dest_r;
  assign out_ch.out_source    = o_src_r;
  assign out_ch.out_serial    = o_ser_r;
  assign out_ch.timer_delay   = o_delay_r;
  assign out_ch.discard_total = o_disc_r;
  assign out_ch.last          = o_last_r;

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the ALOHA acknowledged MAC.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import aarm_pkg::*;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  dest_addr;
    logic [7:0]  src_addr;
    logic        frame_type;
    logic [15:0] serial;
    logic [15:0] random_draw;
  } frame_req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        out_type;
    logic [7:0]  out_dest;
    logic [7:0]  out_source;
    logic [15:0] out_serial;
    logic [16:0] timer_delay;
    logic [31:0] discard_total;
    logic        last;
  } mac_action_t;

  typedef struct {
    bit          valid;
    logic [15:0] serial;
    logic [7:0]  dest;
    logic [2:0]  budget;
  } retry_slot_t;

  typedef struct {
    bit          valid;
    logic [15:0] serial;
    logic [7:0]  src;
  } seen_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  aarm_in_if  in_ch ();
  aarm_out_if out_ch ();
  aarm_cfg_if cfg_ch ();

  aloha_ack_retransmit_mac dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state.
  logic [7:0]  m_own;
  logic [15:0] m_min_delay;
  logic [15:0] m_range;
  logic [2:0]  m_max_retry;
  logic [15:0] m_next_serial;
  retry_slot_t m_pending [PENDING_DEPTH_DEF];
  seen_pair_t  m_history [HISTORY_DEPTH_DEF];
  int          m_hist_head;
  logic [31:0] m_discards;

  frame_req_t  req_queue [$];
  mac_action_t expected_actions [$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  longint      cycles = 0;

  function automatic logic [16:0] backoff_delay(logic [15:0] draw);
    logic [16:0] extra;
    extra = (m_range != 0) ? 17'(draw % m_range) : 17'd0;
    return extra + 17'(m_min_delay);
  endfunction

  function automatic int pending_slot(logic [15:0] ser);
    for (int i = 0; i < PENDING_DEPTH_DEF; i++)
      if (m_pending[i].valid && m_pending[i].serial == ser) return i;
    return -1;
  endfunction

  task automatic push_action(act_t act, logic typ, logic [7:0] dst, logic [7:0] src,
                             logic [15:0] ser, logic [16:0] delay);
    mac_action_t a;
    a.action = act;
    a.out_type = typ;
    a.out_dest = dst;
    a.out_source = src;
    a.out_serial = ser;
    a.timer_delay = delay;
    a.discard_total = m_discards;
    a.last = 1'b0;
    expected_actions.insert(expected_actions.size(), a);
  endtask

  task automatic predict_actions(frame_req_t r);
    int before_n;
    int slot;
    bit dup;
    logic [15:0] s;
    before_n = expected_actions.size();
    if (r.operation == OP_SEND) begin
      s = m_next_serial;
      m_next_serial = m_next_serial + 16'd1;
      push_action(ACT_TX_DATA, 1'b0, r.dest_addr, m_own, s, 17'd0);
      if (r.dest_addr != BCAST_ADDR) begin
        slot = pending_slot(s);
        if (slot < 0)
          for (int i = 0; i < PENDING_DEPTH_DEF; i++)
            if (!m_pending[i].valid) begin
              slot = i;
              break;
            end
        if (slot >= 0) begin
          m_pending[slot].valid = 1'b1;
          m_pending[slot].serial = s;
          m_pending[slot].dest = r.dest_addr;
          m_pending[slot].budget = m_max_retry;
        end
        push_action(ACT_ARM, 1'b0, r.dest_addr, m_own, s, backoff_delay(r.random_draw));
      end
      push_action(ACT_DONE, 1'b0, r.dest_addr, m_own, s, 17'd0);
    end else if (r.operation == OP_RECV) begin
      if (r.frame_type == FT_DATA) begin
        if (r.dest_addr == m_own) begin
          dup = 1'b0;
          for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
            if (m_history[i].valid && m_history[i].serial == r.serial &&
                m_history[i].src == r.src_addr) dup = 1'b1;
          m_history[m_hist_head] = '{1'b1, r.serial, r.src_addr};
          m_hist_head = (m_hist_head + 1) % HISTORY_DEPTH_DEF;
          if (!dup)
            push_action(ACT_DELIVER, 1'b0, r.dest_addr, r.src_addr, r.serial, 17'd0);
          push_action(ACT_TX_ACK, 1'b1, r.src_addr, m_own, r.serial, 17'd0);
        end else if (r.dest_addr == BCAST_ADDR) begin
          push_action(ACT_DELIVER, 1'b0, r.dest_addr, r.src_addr, r.serial, 17'd0);
        end
      end else begin
        slot = pending_slot(r.serial);
        if (slot >= 0 && m_pending[slot].dest == r.src_addr && r.dest_addr == m_own)
          m_pending[slot].valid = 1'b0;
      end
    end else if (r.operation == OP_TIMEOUT) begin
      slot = pending_slot(r.serial);
      if (slot >= 0) begin
        push_action(ACT_RETX, 1'b0, m_pending[slot].dest, m_own, r.serial, 17'd0);
        if (m_pending[slot].budget <= 3'd1) begin
          m_pending[slot].budget = 3'd0;
          m_pending[slot].valid = 1'b0;
          m_discards = m_discards + 32'd1;
          push_action(ACT_DISCARD, 1'b0, m_pending[slot].dest, m_own, r.serial, 17'd0);
        end else begin
          m_pending[slot].budget = m_pending[slot].budget - 3'd1;
          push_action(ACT_ARM, 1'b0, m_pending[slot].dest, m_own, r.serial,
                      backoff_delay(r.random_draw));
        end
      end
    end
    if (expected_actions.size() > before_n)
      expected_actions[expected_actions.size() - 1].last = 1'b1;
  endtask

  // Driver: one item per handshake, changes on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 14);
          in_ch.valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          frame_req_t r;
          r = req_queue[0];
          req_queue.delete(0);
          in_ch.valid <= 1'b1;
          in_ch.operation <= r.operation;
          in_ch.dest_addr <= r.dest_addr;
          in_ch.src_addr <= r.src_addr;
          in_ch.frame_type <= r.frame_type;
          in_ch.serial <= r.serial;
          in_ch.random_draw <= r.random_draw;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      cycles <= cycles + 1;
      if (in_ch.valid && in_ch.ready)
        predict_actions('{in_ch.operation, in_ch.dest_addr, in_ch.src_addr,
                          in_ch.frame_type, in_ch.serial, in_ch.random_draw});
      if (out_ch.valid && out_ch.ready) begin
        mac_action_t got;
        mac_action_t want;
        got = '{out_ch.action, out_ch.out_type, out_ch.out_dest, out_ch.out_source,
                out_ch.out_serial, out_ch.timer_delay, out_ch.discard_total, out_ch.last};
        if (expected_actions.size() == 0) begin
          $display("%0t: unexpected action item %h", $time, got);
          errors++;
        end else begin
          want = expected_actions[0];
          expected_actions.delete(0);
          if (got !== want) begin
            $display("%0t: action mismatch expected %h actual %h", $time, want, got);
            errors++;
          end
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_OWN_ADDR:  m_own = value[7:0];
      REG_MIN_DELAY: m_min_delay = value;
      REG_RANGE:     m_range = value;
      default:       m_max_retry = value[2:0];
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic add_req(logic [1:0] op, logic [7:0] dst, logic [7:0] src, logic ft,
                         logic [15:0] ser, logic [15:0] draw);
    frame_req_t r;
    r = '{op, dst, src, ft, ser, draw};
    req_queue.insert(req_queue.size(), r);
  endtask

  // Waits until the block has drained everything queued so far.
  task automatic drain;
    while (req_queue.size() > 0 || in_ch.valid || expected_actions.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(int n, logic [7:0] peer);
    int op_pick;
    logic [15:0] ser;
    for (int k = 0; k < n; k++) begin
      op_pick = $urandom_range(0, 99);
      ser = m_next_serial + 16'(req_queue.size()) - 16'($urandom_range(0, 20));
      if (op_pick < 30)
        add_req(OP_SEND, ($urandom_range(0, 9) == 0) ? BCAST_ADDR :
                ($urandom_range(0, 3) == 0 ? 8'($urandom) : peer),
                8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      else if (op_pick < 55)
        add_req(OP_TIMEOUT, 8'($urandom), 8'($urandom), 1'($urandom),
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : ser, 16'($urandom));
      else if (op_pick < 75)
        add_req(OP_RECV, ($urandom_range(0, 5) == 0) ? 8'($urandom) : m_own,
                ($urandom_range(0, 3) == 0) ? 8'($urandom) : peer, FT_ACK,
                ser, 16'($urandom));
      else if (op_pick < 97)
        add_req(OP_RECV, ($urandom_range(0, 7) == 0) ? BCAST_ADDR :
                ($urandom_range(0, 7) == 0 ? 8'($urandom) : m_own),
                8'($urandom_range(0, 3)), FT_DATA, 16'($urandom_range(0, 40)),
                16'($urandom));
      else
        add_req(OP_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  initial begin
    m_own = OWN_ADDR_RST;
    m_min_delay = MIN_DELAY_RST;
    m_range = RANGE_RST;
    m_max_retry = MAX_RETRY_RST;
    m_next_serial = '0;
    m_hist_head = 0;
    m_discards = '0;
    foreach (m_pending[i]) m_pending[i] = '{1'b0, 16'd0, 8'd0, 3'd0};
    foreach (m_history[i]) m_history[i] = '{1'b0, 16'd0, 8'd0};
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SEND;
    in_ch.dest_addr = '0;
    in_ch.src_addr = '0;
    in_ch.frame_type = FT_DATA;
    in_ch.serial = '0;
    in_ch.random_draw = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_OWN_ADDR;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with reset settings.
    add_req(OP_SEND, 8'd7, 8'd0, FT_DATA, 16'd0, 16'hFFFF);
    add_req(OP_SEND, BCAST_ADDR, 8'hFF, FT_ACK, 16'hFFFF, 16'd0);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, 16'd0, 16'd5);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, 16'd0, 16'd6);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, 16'd0, 16'd7);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, 16'd0, 16'd7);
    add_req(OP_SEND, 8'd0, 8'd0, FT_DATA, 16'd0, 16'd3);
    add_req(OP_RECV, 8'd1, 8'd0, FT_ACK, 16'd2, 16'd0);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, 16'd2, 16'd0);
    add_req(OP_RECV, 8'd1, 8'd9, FT_DATA, 16'hFFFF, 16'd0);
    add_req(OP_RECV, 8'd1, 8'd9, FT_DATA, 16'hFFFF, 16'd0);
    add_req(OP_RECV, BCAST_ADDR, 8'hFF, FT_DATA, 16'd4, 16'd0);
    add_req(OP_RECV, 8'd2, 8'd9, FT_DATA, 16'd4, 16'd0);
    add_req(OP_NONE, 8'hFF, 8'hFF, FT_ACK, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 18; i++)
      add_req(OP_SEND, 8'd3, 8'd0, FT_DATA, 16'd0, 16'(i * 3641));
    // Wait until the queued items have been taken and their actions checked.
    drain();

    // Broadcast own address, zero range and retries, extreme delays.
    cfg_write(REG_OWN_ADDR, 16'h00FF);
    cfg_write(REG_MIN_DELAY, 16'hFFFF);
    cfg_write(REG_RANGE, 16'd0);
    cfg_write(REG_MAX_RETRY, 16'd0);
    add_req(OP_RECV, BCAST_ADDR, 8'd4, FT_DATA, 16'd1, 16'd0);
    add_req(OP_SEND, 8'd5, 8'd0, FT_DATA, 16'd0, 16'hFFFF);
    add_req(OP_TIMEOUT, 8'd0, 8'd0, FT_DATA, m_next_serial, 16'd0);
    random_phase(60, 8'd5);
    drain();

    cfg_write(REG_OWN_ADDR, 16'd0);
    cfg_write(REG_MIN_DELAY, 16'd0);
    cfg_write(REG_RANGE, 16'hFFFF);
    cfg_write(REG_MAX_RETRY, 16'd7);
    random_phase(110, 8'd200);
    drain();

    cfg_write(REG_OWN_ADDR, 16'd254);
    cfg_write(REG_MIN_DELAY, 16'd100);
    cfg_write(REG_RANGE, 16'd1);
    cfg_write(REG_MAX_RETRY, 16'd1);
    random_phase(110, 8'd0);
    drain();

    cfg_write(REG_OWN_ADDR, 16'h00AA);
    cfg_write(REG_MIN_DELAY, 16'h5555);
    cfg_write(REG_RANGE, 16'hAAAA);
    cfg_write(REG_MAX_RETRY, 16'd2);
    random_phase(70, 8'h55);
    calm = 1'b1;
    random_phase(50, 8'h55);
    drain();

    if (errors == 0 && expected_actions.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 1000000) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
